@@ rtl/caisolv_pkg.sv @@
// Package for the constant-acceleration interval solver.
// Holds the status codes shared by the pipeline stages; no dependencies.
package caisolv_pkg;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StNoRoot  = 3'd1,
    StBadArg  = 3'd2,
    StZeroVA  = 3'd3,
    StSat     = 3'd4
  } status_e;

endpackage

@@ rtl/caisolv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing.
module caisolv_div #(
  parameter int unsigned NumBits = 48,
  parameter int unsigned DenBits = 32,
  parameter int unsigned TagBits = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [NumBits-1:0] num_i,
  input  logic [DenBits-1:0] den_i,
  input  logic [TagBits-1:0] tag_i,
  output logic               valid_o,
  output logic [NumBits-1:0] quo_o,
  output logic [TagBits-1:0] tag_o
);

  logic [NumBits:0]   vld_q;
  logic [DenBits:0]   rem_q [NumBits+1];
  logic [NumBits-1:0] num_q [NumBits+1];
  logic [NumBits-1:0] quo_q [NumBits+1];
  logic [DenBits-1:0] den_q [NumBits+1];
  logic [TagBits-1:0] tag_q [NumBits+1];

  always_comb begin
    vld_q[0] = valid_i;
    rem_q[0] = '0;
    num_q[0] = num_i;
    quo_q[0] = '0;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
  end

  for (genvar g = 0; g < NumBits; g++) begin : gen_stage
    logic [DenBits+1:0] sh;
    logic [DenBits+1:0] df;
    assign sh = {rem_q[g], num_q[g][NumBits-1]};
    assign df = sh - {2'b00, den_q[g]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!df[DenBits+1]) begin
          rem_q[g+1] <= df[DenBits:0];
        end else begin
          rem_q[g+1] <= sh[DenBits:0];
        end
        num_q[g+1] <= num_q[g] << 1;
        quo_q[g+1] <= {quo_q[g][NumBits-2:0], ~df[DenBits+1]};
        den_q[g+1] <= den_q[g];
        tag_q[g+1] <= tag_q[g];
      end
    end
  end

  assign valid_o = vld_q[NumBits];
  assign quo_o   = quo_q[NumBits];
  assign tag_o   = tag_q[NumBits];

endmodule

@@ rtl/caisolv_sqrt.sv @@
// Pipelined integer floor square root, one root bit per stage.
// Depends on nothing; carries a tag word alongside each operand.
module caisolv_sqrt #(
  parameter int unsigned RootBits = 33,
  parameter int unsigned TagBits  = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2*RootBits-1:0] rad_i,
  input  logic [TagBits-1:0]    tag_i,
  output logic                  valid_o,
  output logic [RootBits-1:0]   root_o,
  output logic [TagBits-1:0]    tag_o
);

  localparam int unsigned RadBits = 2 * RootBits;

  logic [RootBits:0]   vld_q;
  logic [RootBits+1:0] rem_q [RootBits+1];
  logic [RadBits-1:0]  rad_q [RootBits+1];
  logic [RootBits-1:0] root_q [RootBits+1];
  logic [TagBits-1:0]  tag_q [RootBits+1];

  always_comb begin
    vld_q[0]  = valid_i;
    rem_q[0]  = '0;
    rad_q[0]  = rad_i;
    root_q[0] = '0;
    tag_q[0]  = tag_i;
  end

  // Digit recurrence: rem = 4*rem + next pair; trial = 4*root + 1.
  for (genvar g = 0; g < RootBits; g++) begin : gen_stage
    logic [RootBits+3:0] sh;
    logic [RootBits+3:0] tr;
    logic [RootBits+3:0] df;
    assign sh = {rem_q[g], rad_q[g][RadBits-1 -: 2]};
    assign tr = {root_q[g], 2'b01};
    assign df = sh - tr;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!df[RootBits+3]) begin
          rem_q[g+1] <= df[RootBits+1:0];
        end else begin
          rem_q[g+1] <= sh[RootBits+1:0];
        end
        rad_q[g+1]  <= rad_q[g] << 2;
        root_q[g+1] <= {root_q[g][RootBits-2:0], ~df[RootBits+3]};
        tag_q[g+1]  <= tag_q[g];
      end
    end
  end

  assign valid_o = vld_q[RootBits];
  assign root_o  = root_q[RootBits];
  assign tag_o   = tag_q[RootBits];

endmodule

@@ rtl/constant_accel_interval_solver_core.sv @@
// Constant-acceleration interval solver, fixed point Q(FRAC_BITS).
// Pipeline: decode, products, discriminant, root pipeline, divider, output register.
// Throughput: one request per cycle; the root and divider are fully pipelined
// with one bit per stage, and a stall freezes the whole pipe.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// Uses caisolv_pkg, caisolv_sqrt and caisolv_div.
module constant_accel_interval_solver_core #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic                 kind_i,
  input  logic [WORD_BITS-1:0] accel_i,
  input  logic [WORD_BITS-1:0] known_speed_i,
  input  logic [WORD_BITS-1:0] start_pos_i,
  input  logic [WORD_BITS-1:0] end_pos_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [WORD_BITS-1:0] duration_o,
  output logic [WORD_BITS-1:0] other_speed_o,
  output caisolv_pkg::status_e status_o
);
  import caisolv_pkg::*;

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned RB = W + 1;          // root width
  localparam int unsigned DW = 2 * RB;         // radicand width
  localparam int unsigned NB = W + FRAC_BITS;  // dividend width
  // Tag: early status (3), speed v (W), |a| (W), distance d (W).
  localparam int unsigned TB = 3 + 3 * W;
  // Divider tag: status (3), root saturation, dividend saturation, other speed (W).
  localparam int unsigned DTB = W + 5;

  // The whole pipe advances when the output register can take a new value.
  logic en;
  assign en      = !valid_o || ready_i;
  assign ready_o = en;

  // ---- Stage 1: decode, magnitude of a, distance, argument checks.
  logic          s1_vld_q;
  logic          s1_kind_q, s1_neg_q;
  logic [W-1:0]  s1_v_q, s1_amag_q, s1_d_q;
  status_e       s1_st_q;
  logic          s1_neg, s1_bad;
  logic [W-1:0]  s1_amag;
  assign s1_neg  = accel_i[W-1];
  assign s1_amag = s1_neg ? (~accel_i + 1'b1) : accel_i;
  assign s1_bad  = (start_pos_i >= end_pos_i) || (kind_i && !s1_neg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_kind_q <= kind_i;
      s1_neg_q  <= s1_neg;
      s1_v_q    <= known_speed_i;
      s1_amag_q <= s1_amag;
      s1_d_q    <= end_pos_i - start_pos_i;
      if (s1_bad) begin
        s1_st_q <= StBadArg;
      end else if (s1_amag == '0 && known_speed_i == '0) begin
        s1_st_q <= StZeroVA;
      end else begin
        s1_st_q <= StOk;
      end
    end
  end

  // ---- Stage 2: the two products.
  logic          s2_vld_q, s2_sub_q;
  logic [2*W-1:0] s2_vsq_q, s2_ad_q;
  logic [W-1:0]  s2_v_q, s2_amag_q, s2_d_q;
  status_e       s2_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_vsq_q  <= s1_v_q * s1_v_q;
      s2_ad_q   <= s1_amag_q * s1_d_q;
      s2_sub_q  <= !s1_kind_q && s1_neg_q;
      s2_v_q    <= s1_v_q;
      s2_amag_q <= s1_amag_q;
      s2_d_q    <= s1_d_q;
      s2_st_q   <= s1_st_q;
    end
  end

  // ---- Stage 3: discriminant and the negative check.
  logic          s3_vld_q;
  logic [DW-1:0] s3_disc_q;
  logic [W-1:0]  s3_v_q, s3_amag_q, s3_d_q;
  status_e       s3_st_q;
  logic [DW-1:0] s3_vsq, s3_twoad;
  assign s3_vsq   = DW'(s2_vsq_q);
  assign s3_twoad = {1'b0, s2_ad_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_v_q    <= s2_v_q;
      s3_amag_q <= s2_amag_q;
      s3_d_q    <= s2_d_q;
      s3_st_q   <= s2_st_q;
      if (s2_sub_q) begin
        s3_disc_q <= s3_vsq - s3_twoad;
        if (s2_st_q == StOk && s3_twoad > s3_vsq) begin
          s3_st_q <= StNoRoot;
        end
      end else begin
        s3_disc_q <= s3_vsq + s3_twoad;
      end
    end
  end

  // ---- Root pipeline.
  logic          rt_vld;
  logic [RB-1:0] rt_root;
  logic [TB-1:0] rt_tag;

  caisolv_sqrt #(.RootBits(RB), .TagBits(TB)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .rad_i   (s3_disc_q),
    .tag_i   ({3'(s3_st_q), s3_v_q, s3_amag_q, s3_d_q}),
    .valid_o (rt_vld),
    .root_o  (rt_root),
    .tag_o   (rt_tag)
  );

  logic [2:0]   rt_st;
  logic [W-1:0] rt_v, rt_amag, rt_d;
  assign {rt_st, rt_v, rt_amag, rt_d} = rt_tag;

  // Choose dividend and divisor: d/v when a is zero, |root - v|/|a| otherwise.
  logic          rt_azero;
  logic [RB-1:0] rt_diff;
  logic [NB-1:0] dv_num;
  logic [W-1:0]  dv_den;
  logic          dv_rsat;
  logic [W-1:0]  dv_other;
  assign rt_azero = (rt_amag == '0);
  assign rt_diff  = (rt_root >= RB'(rt_v)) ? (rt_root - RB'(rt_v)) : (RB'(rt_v) - rt_root);
  always_comb begin
    if (rt_azero) begin
      dv_num   = {rt_d, FRAC_BITS'(0)};
      dv_den   = rt_v;
      dv_rsat  = 1'b0;
      dv_other = rt_v;
    end else begin
      // diff is below 2^(W+1), so its top bit alone marks overflow.
      dv_num   = rt_diff[RB-1] ? '1 : {rt_diff[W-1:0], FRAC_BITS'(0)};
      dv_den   = rt_amag;
      dv_rsat  = rt_root[RB-1];
      dv_other = rt_root[RB-1] ? '1 : rt_root[W-1:0];
    end
  end

  logic           dq_vld;
  logic [NB-1:0]  dq_quo;
  logic [DTB-1:0] dq_tag;
  logic [2:0]     dq_st;
  logic           dq_rsat, dq_nsat;
  logic [W-1:0]   dq_other;

  // A diff of 2^W or more gives a dividend beyond NB bits; it always saturates.
  caisolv_div #(.NumBits(NB), .DenBits(W), .TagBits(DTB)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_vld),
    .num_i   (dv_num),
    .den_i   (dv_den),
    .tag_i   ({rt_st, dv_rsat, !rt_azero && rt_diff[RB-1], dv_other}),
    .valid_o (dq_vld),
    .quo_o   (dq_quo),
    .tag_o   (dq_tag)
  );
  assign {dq_st, dq_rsat, dq_nsat, dq_other} = dq_tag;

  // ---- Output register.
  logic         out_vld_q;
  logic [W-1:0] dur_q, oth_q;
  status_e      st_q;
  logic         dq_qsat;
  assign dq_qsat = dq_nsat || (dq_quo[NB-1:W] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dq_vld;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (status_e'(dq_st) != StOk) begin
        dur_q <= '0;
        oth_q <= '0;
        st_q  <= status_e'(dq_st);
      end else begin
        dur_q <= dq_qsat ? '1 : dq_quo[W-1:0];
        oth_q <= dq_other;
        st_q  <= (dq_qsat || dq_rsat) ? StSat : StOk;
      end
    end
  end

  assign valid_o       = out_vld_q;
  assign duration_o    = dur_q;
  assign other_speed_o = oth_q;
  assign status_o      = st_q;

  // An error status always comes with zeroed result fields.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == StBadArg || status_o == StNoRoot || status_o == StZeroVA)
      |-> (duration_o == '0 && other_speed_o == '0))
    else $error("error status with nonzero result");
  // A stalled output holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !ready_i |=> valid_o && $stable(duration_o) && $stable(status_o))
    else $error("output changed under stall");
  // The input is ready exactly when the output is not blocked.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_o == (!valid_o || ready_i))
    else $error("ready does not follow the output stage");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for constant_accel_interval_solver_core.
// Drives interval requests through a clocked driver, predicts each answer with a
// fixed-point kinematics solver of its own, and checks results in order. Uses caisolv_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import caisolv_pkg::*;

  localparam int unsigned WB = 32;
  localparam int unsigned FB = 16;
  localparam int unsigned LATENCY = 3 + (WB + 1) + (WB + FB) + 1;
  localparam int unsigned NUM_RANDOM = 500;
  localparam int unsigned PAUSE_AT = 260;
  localparam logic [WB-1:0] WMAX = '1;

  // One interval request as presented to the block.
  typedef struct packed {
    logic          kind;
    logic [WB-1:0] accel;
    logic [WB-1:0] speed;
    logic [WB-1:0] spos;
    logic [WB-1:0] epos;
  } interval_t;

  // The answer the solver is expected to return for one interval.
  typedef struct packed {
    logic [WB-1:0] duration;
    logic [WB-1:0] other_speed;
    status_e       status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_o;
  logic kind_i = 1'b0;
  logic [WB-1:0] accel_i = '0;
  logic [WB-1:0] known_speed_i = '0;
  logic [WB-1:0] start_pos_i = '0;
  logic [WB-1:0] end_pos_i = '0;
  logic valid_o;
  logic ready_i = 1'b0;
  logic [WB-1:0] duration_o;
  logic [WB-1:0] other_speed_o;
  status_e status_o;

  interval_t pending_q[$];
  answer_t   answers_q[$];
  bit        stimulus_done = 1'b0;
  bit        drained_once = 1'b0;
  int unsigned requests_sent = 0;
  int unsigned answers_seen = 0;
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned status_seen[5] = '{default: 0};

  constant_accel_interval_solver_core #(
    .WORD_BITS(WB),
    .FRAC_BITS(FB)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .ready_o      (ready_o),
    .kind_i       (kind_i),
    .accel_i      (accel_i),
    .known_speed_i(known_speed_i),
    .start_pos_i  (start_pos_i),
    .end_pos_i    (end_pos_i),
    .valid_o      (valid_o),
    .ready_i      (ready_i),
    .duration_o   (duration_o),
    .other_speed_o(other_speed_o),
    .status_o     (status_o)
  );

  always #10 clk_i = ~clk_i;

  // Saturating truncated quotient (num << FB) / den, flagging overflow.
  function automatic logic [WB-1:0] scaled_quotient(logic [127:0] num, logic [127:0] den,
                                                   ref bit sat);
    logic [127:0] q;
    q = (num << FB) / den;
    if (q > {96'd0, WMAX}) begin
      sat = 1'b1;
      return WMAX;
    end
    return q[WB-1:0];
  endfunction

  // Exact floor square root of a Q(2*FB) value, giving Q(FB).
  function automatic logic [127:0] floor_root(logic [127:0] x);
    logic [127:0] root;
    logic [127:0] cand;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= x) root = cand;
    end
    return root;
  endfunction

  // Closed-form constant-acceleration solution of one interval.
  function automatic answer_t solve_interval(interval_t it);
    answer_t ans;
    bit neg;
    bit sat;
    logic [WB-1:0] amag;
    logic [127:0] distance, vsq, twoad, disc, root, diff;
    ans = '{duration: '0, other_speed: '0, status: StOk};
    sat = 1'b0;
    neg = it.accel[WB-1];
    amag = neg ? -it.accel : it.accel;
    if (it.spos >= it.epos || (it.kind && (!neg || amag == 0))) begin
      ans.status = StBadArg;
      return ans;
    end
    distance = 128'(it.epos - it.spos);
    if (amag == 0) begin
      // Coasting: time is distance over speed, speed is unchanged.
      if (it.speed == 0) begin
        ans.status = StZeroVA;
        return ans;
      end
      ans.duration = scaled_quotient(distance, 128'(it.speed), sat);
      ans.other_speed = it.speed;
    end else begin
      vsq = 128'(it.speed) * 128'(it.speed);
      twoad = (128'(amag) * distance) << 1;
      if (!it.kind && neg) begin
        // Braking forward: the body may stop before reaching the end.
        if (twoad > vsq) begin
          ans.status = StNoRoot;
          return ans;
        end
        disc = vsq - twoad;
      end else begin
        disc = vsq + twoad;
      end
      root = floor_root(disc);
      diff = (root >= 128'(it.speed)) ? root - 128'(it.speed) : 128'(it.speed) - root;
      ans.duration = scaled_quotient(diff, 128'(amag), sat);
      if (root > {96'd0, WMAX}) begin
        ans.other_speed = WMAX;
        sat = 1'b1;
      end else begin
        ans.other_speed = root[WB-1:0];
      end
    end
    if (sat) ans.status = StSat;
    return ans;
  endfunction

  task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
    errors++;
    $display("MISMATCH answer %0d %s: got 0x%08h expected 0x%08h", answers_seen, what, got, want);
  endtask

  function automatic interval_t mk(logic k, logic [WB-1:0] a, logic [WB-1:0] v,
                                   logic [WB-1:0] s, logic [WB-1:0] e);
    return '{kind: k, accel: a, speed: v, spos: s, epos: e};
  endfunction

  // A random word, often shrunk so that the interesting small ranges are hit.
  function automatic logic [WB-1:0] rand_word();
    logic [WB-1:0] w;
    w = $urandom;
    if ($urandom_range(0, 2) == 0) w = w >> $urandom_range(0, 31);
    return w;
  endfunction

  function automatic interval_t rand_interval();
    interval_t it;
    logic [WB-1:0] span;
    it.kind = $urandom_range(0, 1);
    it.accel = rand_word();
    it.speed = rand_word();
    if ($urandom_range(0, 9) < 8) begin
      // Well-formed: forward end beyond start, reverse with braking acceleration.
      it.spos = rand_word();
      span = rand_word();
      if (span == 0) span = 1;
      if (span > WMAX - it.spos) span = WMAX - it.spos;
      if (span == 0) it.spos = it.spos - 1;
      if (span == 0) span = 1;
      it.epos = it.spos + span;
      if (it.kind) it.accel = -(it.accel | 32'h1) | 32'h8000_0000;
      if (!it.kind && $urandom_range(0, 9) == 0) it.accel = '0;
    end else begin
      it.accel = $urandom;
      it.speed = $urandom;
      it.spos = $urandom;
      it.epos = $urandom;
    end
    return it;
  endfunction

  // Driver: offers the next pending request and records its answer on acceptance.
  always @(posedge clk_i) begin
    bit idle;
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (valid_i && ready_o) begin
        answers_q.push_back(solve_interval(interval_t'({kind_i, accel_i, known_speed_i,
                                                        start_pos_i, end_pos_i})));
        requests_sent <= requests_sent + 1;
      end
      if (!valid_i || ready_o) begin
        idle = ($urandom_range(0, 99) < 16) && !(requests_sent inside {[80:200]});
        // Hold off once mid-run until the pipe has fully drained.
        if (requests_sent + (valid_i && ready_o) == PAUSE_AT && !drained_once) begin
          idle = 1'b1;
          if (answers_q.size() == 0 && !(valid_i && ready_o)) drained_once <= 1'b1;
        end
        if (!idle && pending_q.size() != 0) begin
          interval_t nxt;
          nxt = pending_q.pop_front();
          valid_i <= 1'b1;
          kind_i <= nxt.kind;
          accel_i <= nxt.accel;
          known_speed_i <= nxt.speed;
          start_pos_i <= nxt.spos;
          end_pos_i <= nxt.epos;
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and in-order comparison of every answer.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni) begin
      if (valid_o && ready_i) begin
        if (answers_q.size() == 0) begin
          report_mismatch("with nothing outstanding", duration_o, '0);
        end else begin
          want = answers_q.pop_front();
          if (duration_o !== want.duration)
            report_mismatch("duration", duration_o, want.duration);
          if (other_speed_o !== want.other_speed)
            report_mismatch("other_speed", other_speed_o, want.other_speed);
          if (status_o !== want.status)
            report_mismatch("status", WB'(status_o), WB'(want.status));
          if (want.status <= StSat) status_seen[want.status]++;
        end
        answers_seen <= answers_seen + 1;
      end
      ready_i <= !(($urandom_range(0, 99) < 16) && !(cycle_cnt inside {[300:700]}));
    end
  end

  initial begin
    // Directed corners: argument errors, coasting, braking, saturation, extremes.
    pending_q.push_back(mk(0, 32'h0001_0000, 32'h0001_0000, 32'h10, 32'h10));
    pending_q.push_back(mk(0, 32'h0001_0000, 32'h0001_0000, WMAX, 32'h0));
    pending_q.push_back(mk(1, 32'h0001_0000, 32'h0001_0000, 0, 32'h0001_0000));
    pending_q.push_back(mk(1, 32'h0, 32'h0001_0000, 0, 32'h0001_0000));
    pending_q.push_back(mk(0, 32'h0, 32'h0, 0, 32'h0001_0000));
    pending_q.push_back(mk(0, 32'h0, 32'h0002_0000, 0, 32'h000A_0000));
    pending_q.push_back(mk(0, 32'h0, 32'h0000_0001, 0, WMAX));
    pending_q.push_back(mk(0, 32'h0, WMAX, 0, WMAX));
    pending_q.push_back(mk(0, 32'hFFFF_0000, 32'h0001_0000, 0, 32'h0064_0000));
    pending_q.push_back(mk(0, 32'hFFFE_0000, 32'h0002_0000, 0, 32'h0001_0000));
    pending_q.push_back(mk(0, 32'h0002_0000, 32'h0, 0, 32'h0004_0000));
    pending_q.push_back(mk(0, 32'h0000_0001, 32'h0, 0, WMAX));
    pending_q.push_back(mk(0, 32'h7FFF_FFFF, WMAX, 0, WMAX));
    pending_q.push_back(mk(0, 32'h8000_0000, WMAX, 0, 32'h1));
    pending_q.push_back(mk(0, 32'h8000_0000, 32'h0, 0, 32'h1));
    pending_q.push_back(mk(0, 32'hFFFF_FFFF, WMAX, 0, WMAX));
    pending_q.push_back(mk(1, 32'hFFFF_0000, 32'h0, 0, 32'h0001_0000));
    pending_q.push_back(mk(1, 32'h8000_0000, WMAX, 0, WMAX));
    pending_q.push_back(mk(1, 32'hFFFF_FFFF, 32'h0, 0, WMAX));
    pending_q.push_back(mk(1, 32'hFFFF_FFFF, WMAX, WMAX - 1, WMAX));
    pending_q.push_back(mk(1, 32'h8000_0000, 32'h0, 0, WMAX));
    pending_q.push_back(mk(0, 32'h0, 32'h0001_0000, 0, 32'h0000_0001));
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      // Keep the queue shallow so the driver never starves for long.
      while (pending_q.size() > 8) @(posedge clk_i);
      pending_q.push_back(rand_interval());
    end
    while (pending_q.size() != 0 || valid_i) @(posedge clk_i);
    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Sent %0d intervals, checked %0d answers.", requests_sent, answers_seen);
    $display("Status mix ok/noroot/badarg/zero/sat: %0d/%0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && answers_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d answers outstanding", answers_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/caisolv_pkg.sv
rtl/caisolv_div.sv
rtl/caisolv_sqrt.sv
rtl/constant_accel_interval_solver_core.sv
tb/tb_top.sv
